>>> rtl/rtti_pkg.sv
// ----------------------------------------------------------------------------
// rtti_pkg
// Shared types, codes and the digit decode for the radix text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rtti_pkg;

   // Widths of the register fields and the payload
   localparam int unsigned RADIX_W   = 6;
   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned CSR_IDX_W = 2;

   // Product holds acc * 36 + 35, which stays below 2^70
   localparam int unsigned PROD_W    = VALUE_W + RADIX_W;

   // Step counter walks over the radix bits
   localparam int unsigned STEP_W    = $clog2(RADIX_W);

   // Size of the digit alphabet 0-9 then A-Z
   localparam logic [RADIX_W-1:0] ALPHABET_SIZE = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET   = RADIX_W'(10);

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIX     = 2'd0,
      CSR_MAX_VALUE = 2'd1,
      CSR_MIN_VALUE = 2'd2
   } csr_index_type;

   // Input item kinds
   typedef enum logic {
      KIND_CHAR = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK
   } state_type;

   // Position of a character in 0-9A-Z (lower case folded), or the
   // alphabet size when it is not in the alphabet.
   function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [RADIX_W-1:0] d;
      d = ALPHABET_SIZE;
      if (c inside {[8'h30:8'h39]}) begin
         d = RADIX_W'(c - 8'h30);
      end else if (c inside {[8'h41:8'h5A]}) begin
         d = RADIX_W'(c - 8'h41 + 8'd10);
      end else if (c inside {[8'h61:8'h7A]}) begin
         d = RADIX_W'(c - 8'h61 + 8'd10);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/radix_text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// radix_text_to_integer_parser
// Folds a character stream into an unsigned value in a configurable radix.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  ---------+-----------+----------------------------------------------------
//  req_     | in        | one character or end-of-string marker
//  rsp_     | out       | parsed value and failure flag, one per end marker
//  csr_     | in        | register write: radix, max_value, min_value
//
//  A valid digit passes through the accept step, six shift-and-add steps
//  of the shared 70-bit adder (one radix bit each), and one compare against
//  max_value. Invalid characters, characters after a failure and end
//  markers are handled in the idle state alone. Any transaction, character
//  or end marker, waits while a result is held on a stalled rsp_ channel.
//  Reset is synchronous and returns the registers to radix 10, max all ones, min 0.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_text_to_integer_parser (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // configuration writes
   input  wire logic                         csr_write_en,
   input  wire logic [rtti_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rtti_pkg::VALUE_W-1:0] csr_wdata,
   // input characters
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_kind,
   input  wire logic [rtti_pkg::CHAR_W-1:0]  req_char_code,
   // results
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [rtti_pkg::VALUE_W-1:0]      rsp_value,
   output logic                              rsp_failed
);

   import rtti_pkg::*;

   // Configuration registers
   logic [RADIX_W-1:0] radix_ff;
   logic [VALUE_W-1:0] max_value_ff;
   logic [VALUE_W-1:0] min_value_ff;

   // Parse state
   state_type          state_ff,      state_in;
   logic [VALUE_W-1:0] acc_ff,        acc_in;
   logic               error_seen_ff, error_seen_in;
   logic [PROD_W-1:0]  prod_ff,       prod_in;
   logic [STEP_W-1:0]  step_ff,       step_in;

   // Result register
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff,  rsp_value_in;
   logic               rsp_failed_ff, rsp_failed_in;

   logic               req_take;
   logic [RADIX_W-1:0] radix_eff;
   logic [RADIX_W-1:0] digit;
   logic [PROD_W-1:0]  addend;

   // Radices past the alphabet behave as 36
   assign radix_eff = (radix_ff > ALPHABET_SIZE) ? ALPHABET_SIZE : radix_ff;
   assign digit     = digit_of(req_char_code);

   // A busy sequencer or a held result stalls every transaction
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   // Shifted partial product for the current radix bit
   assign addend = radix_eff[step_ff] ? (PROD_W'(acc_ff) << step_ff) : '0;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         max_value_ff <= '1;
         min_value_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RADIX:     radix_ff     <= csr_wdata[RADIX_W-1:0];
            CSR_MAX_VALUE: max_value_ff <= csr_wdata;
            CSR_MIN_VALUE: min_value_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Sequencer state and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         acc_ff        <= '0;
         error_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         error_seen_ff <= error_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      step_ff       <= step_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      error_seen_in = error_seen_ff;
      prod_in       = prod_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_failed_in = rsp_failed_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_kind == KIND_END) begin
                  // report and clear for the next string
                  rsp_valid_in = 1'b1;
                  if (error_seen_ff || acc_ff < min_value_ff) begin
                     rsp_value_in  = '1;
                     rsp_failed_in = 1'b1;
                  end else begin
                     rsp_value_in  = acc_ff;
                     rsp_failed_in = 1'b0;
                  end
                  acc_in        = '0;
                  error_seen_in = 1'b0;
               end else if (!error_seen_ff) begin
                  if (digit >= radix_eff) begin
                     error_seen_in = 1'b1;
                  end else begin
                     // seed the product with the digit, then add acc * radix
                     prod_in  = PROD_W'(digit);
                     step_in  = '0;
                     state_in = ST_MUL;
                  end
               end
            end
         end

         ST_MUL: begin
            prod_in = prod_ff + addend;
            if (step_ff == STEP_W'(RADIX_W - 1)) begin
               state_in = ST_CHECK;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_CHECK: begin
            // acc * r + d above max covers both overflow checks
            if (prod_ff > PROD_W'(max_value_ff)) begin
               error_seen_in = 1'b1;
            end else begin
               acc_in = prod_ff[VALUE_W-1:0];
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_failed = rsp_failed_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // The multiplier only ever runs for a parse that has not failed
   a_no_mul_after_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !error_seen_ff)
      else $error("sequencer busy on a failed parse");

   // A new result only follows an accepted end marker
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(req_take && req_kind == KIND_END))
      else $error("result without an end marker");

   // The compare step always returns the sequencer to idle
   a_check_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |=> (state_ff == ST_IDLE))
      else $error("compare step did not return to idle");

   // A failed result always carries all ones
   a_failed_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_failed_ff) |-> (&rsp_value_ff))
      else $error("failed result without all-ones value");

endmodule

`default_nettype wire

>>> tb/radix_text_to_integer_parser_tb.sv
// ----------------------------------------------------------------------------
// radix_text_to_integer_parser_tb
// Self-checking bench for the radix text parser. Number strings are sent a
// character at a time, each closed by an end marker. A cycle-free model of
// the parse predicts the value and failure flag for every end marker, and
// each result is checked against it in order. The run moves through a range
// of radix and bound settings under random idling on both channels.
// ----------------------------------------------------------------------------

module radix_text_to_integer_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtti_pkg::*;

   localparam int unsigned CLK_HALF      = 4;
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned NUM_PHASES    = 14;
   localparam int unsigned PHASE_ITEMS   = 160;
   localparam logic [VALUE_W-1:0] ALL_ONES = '1;
   // index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               failed;
   } parse_result_type;

   // Tracks the parse of each string and holds the results still owed
   class parse_scoreboard;
      logic [RADIX_W-1:0] radix;
      logic [VALUE_W-1:0] max_value;
      logic [VALUE_W-1:0] min_value;
      logic [VALUE_W-1:0] running_value;
      bit                 parse_failed;
      parse_result_type   pending_parses[$];
      int                 errors;
      int                 items_taken;
      int                 strings_taken;
      int                 results_checked;

      function new();
         radix           = RADIX_RESET;
         max_value       = ALL_ONES;
         min_value       = '0;
         running_value   = '0;
         parse_failed    = 1'b0;
         errors          = 0;
         items_taken     = 0;
         strings_taken   = 0;
         results_checked = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [VALUE_W-1:0] data);
         case (index)
            CSR_RADIX:     radix     = data[RADIX_W-1:0];
            CSR_MAX_VALUE: max_value = data;
            CSR_MIN_VALUE: min_value = data;
            default: ;
         endcase
      endfunction

      // alphabet holds only 36 digits, so larger radices act as 36
      function int unsigned effective_radix();
         return (radix > 36) ? 36 : int'(radix);
      endfunction

      // position in 0-9 then A-Z, lower case folded; 36 when not a digit
      function int unsigned char_digit(logic [CHAR_W-1:0] code);
         if (code >= "0" && code <= "9") return 32'(code - "0");
         if (code >= "A" && code <= "Z") return code - "A" + 10;
         if (code >= "a" && code <= "z") return code - "a" + 10;
         return 36;
      endfunction

      function void accept_item(kind_type kind, logic [CHAR_W-1:0] code);
         int unsigned        r;
         int unsigned        d;
         logic [VALUE_W+7:0] widened;
         items_taken++;
         if (kind == KIND_CHAR) begin
            if (parse_failed) return;
            r = effective_radix();
            d = char_digit(code);
            if (d >= r) begin
               parse_failed = 1'b1;
               return;
            end
            // wide enough that the product and digit never wrap
            widened = {8'd0, running_value} * (VALUE_W+8)'(r) + (VALUE_W+8)'(d);
            if (widened > {8'd0, max_value}) parse_failed = 1'b1;
            else running_value = widened[VALUE_W-1:0];
         end else begin
            strings_taken++;
            if (parse_failed || running_value < min_value) begin
               pending_parses.push_back('{value: ALL_ONES, failed: 1'b1});
            end else begin
               pending_parses.push_back('{value: running_value, failed: 1'b0});
            end
            running_value = '0;
            parse_failed  = 1'b0;
         end
      endfunction

      function void check_result(logic [VALUE_W-1:0] value, logic failed);
         parse_result_type want;
         if (pending_parses.size() == 0) begin
            $error("result with nothing expected: value=%h failed=%b", value, failed);
            errors++;
            return;
         end
         want = pending_parses.pop_front();
         results_checked++;
         if (value !== want.value) begin
            $error("field value: expected %h, got %h", want.value, value);
            errors++;
         end
         if (failed !== want.failed) begin
            $error("field failed: expected %b, got %b", want.failed, failed);
            errors++;
         end
      endfunction

      function int pending();
         return pending_parses.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RADIX;
   logic [VALUE_W-1:0]   csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_kind = KIND_CHAR;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VALUE_W-1:0]   rsp_value;
   logic                 rsp_failed;

   parse_scoreboard sb = new();
   int unsigned     send_idle_pct = 0;
   int unsigned     stall_pct     = 0;
   bit              hold_request  = 1'b0;
   int unsigned     cycle_count   = 0;

   radix_text_to_integer_parser dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_failed    (rsp_failed)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: check accepted transactions, then pick the next stall
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) sb.check_result(rsp_value, rsp_failed);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // One transaction on the request side, with random idle cycles ahead
   task automatic send_item(input kind_type kind, input logic [CHAR_W-1:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_char_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.accept_item(kind, code);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_item(KIND_CHAR, text[i]);
      send_item(KIND_END, CHAR_W'($urandom_range(255)));
   endtask

   // Sender pauses until every owed result is back and the block is quiet
   task automatic wait_for_parses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // All three registers back to back, write enable held across them
   task automatic write_regs(input logic [VALUE_W-1:0] radix_data,
                             input logic [VALUE_W-1:0] max_data,
                             input logic [VALUE_W-1:0] min_data);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_RADIX;
      csr_wdata    <= radix_data;
      sb.write_reg(CSR_RADIX, radix_data);
      @(posedge clock);
      csr_index    <= CSR_MAX_VALUE;
      csr_wdata    <= max_data;
      sb.write_reg(CSR_MAX_VALUE, max_data);
      @(posedge clock);
      csr_index    <= CSR_MIN_VALUE;
      csr_wdata    <= min_data;
      sb.write_reg(CSR_MIN_VALUE, min_data);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Number of digits the bound has in this radix, to size the strings
   function automatic int unsigned digits_for(logic [VALUE_W-1:0] bound, int unsigned r);
      int unsigned n;
      n = 0;
      if (r < 2) return 4;
      while (bound != 0) begin
         bound = bound / r;
         n++;
      end
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(int unsigned d, bit lower);
      if (d < 10) return CHAR_W'("0" + d);
      return lower ? CHAR_W'("a" + d - 10) : CHAR_W'("A" + d - 10);
   endfunction

   function automatic logic [VALUE_W-1:0] random_word();
      return {$urandom, $urandom} >> $urandom_range(0, 63);
   endfunction

   // Mostly well-formed strings; some carry a bad character, some are noise
   task automatic send_string();
      int unsigned       r;
      int unsigned       len;
      int unsigned       flavour;
      int unsigned       bad_at;
      logic [CHAR_W-1:0] code;
      r       = sb.effective_radix();
      len     = $urandom_range(0, digits_for(sb.max_value, r) + 1);
      flavour = $urandom_range(99);
      bad_at  = $urandom_range(0, (len > 0) ? len - 1 : 0);
      for (int unsigned i = 0; i < len; i++) begin
         if (flavour < 12 || r == 0 || (flavour < 27 && i == bad_at)) begin
            code = CHAR_W'($urandom_range(255));
         end else begin
            code = digit_char($urandom_range(0, r - 1), 1'($urandom_range(1)));
         end
         send_item(KIND_CHAR, code);
      end
      send_item(KIND_END, CHAR_W'($urandom_range(255)));
   endtask

   // Stimulus
   initial begin
      int unsigned  target;
      logic [VALUE_W-1:0] bound;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: radix 10, no bounds
      send_text("9");
      send_text("a5");                      // letter past the radix, rest ignored
      send_text("\377");                    // high code
      send_item(KIND_END, 8'h37);           // empty string, code ignored
      send_text("/");                       // punctuation

      for (int unsigned phase = 1; phase < NUM_PHASES; phase++) begin
         wait_for_parses();
         case (phase)
            1:  write_regs(64'd36, ALL_ONES, '0);
            2:  write_regs(64'd2, ALL_ONES, '0);
            3:  write_regs(64'd16, 64'h0000_0000_FFFF_FFFF, 64'd100);
            4:  write_regs(64'd10, '0, '0);           // any non-zero digit overflows
            5:  write_regs(64'd8, ALL_ONES, ALL_ONES);
            6:  write_regs(64'd1, ALL_ONES, '0);      // only '0' is a digit
            7:  write_regs(64'd0, ALL_ONES, '0);      // nothing is a digit
            8:  write_regs({$urandom, 26'($urandom_range(0, 3)), 6'd37}, ALL_ONES, '0);
            9:  write_regs(64'd63, ALL_ONES, '0);
            10: begin
               csr_write_en <= 1'b1;
               csr_index    <= CSR_SPARE;
               csr_wdata    <= {$urandom, $urandom};
               sb.write_reg(CSR_SPARE, '0);
               @(posedge clock);
               csr_write_en <= 1'b0;
               @(posedge clock);
               bound = random_word();
               write_regs(64'd3, bound, bound >> $urandom_range(1, 64));
            end
            default: begin
               bound = random_word();
               write_regs(VALUE_W'($urandom_range(2, 36)), bound,
                          ($urandom_range(3) == 0) ? random_word() : bound >> 8);
            end
         endcase

         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase

         // largest value that fits, in radix 36, in mixed case
         if (phase == 1) send_text("3w5E11264sgsf");

         // long hold on results while strings keep coming
         if (phase == 3) hold_request = 1'b1;

         target = sb.items_taken + PHASE_ITEMS;
         while (sb.items_taken < target) send_string();
      end

      wait_for_parses();
      sb.errors += sb.pending();

      $display("Parsed %0d strings from %0d transactions; %0d results checked.",
               sb.strings_taken, sb.items_taken, sb.results_checked);
      $display("Radix settings 0 to 63 with bounds from 0 to all ones, %0d errors.",
               sb.errors);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/rtti_pkg.sv
rtl/radix_text_to_integer_parser.sv
tb/radix_text_to_integer_parser_tb.sv
